/* rtl/core/ccw_pkg.sv */
// Package for the text console cell writer: geometry constants, byte codes,
// register indexes and the item and store request types. No dependencies.
package ccw_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 32;
    localparam int FLUSH_BURST = 64;
    localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int CUR_W       = ADDR_W + 1;
    localparam int CNT_W       = $clog2(FLUSH_BURST + 1);
    localparam int TAB_STEP    = 4;

    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_BS    = 8'h08;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_DEL   = 8'h7F;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] CHAR_BLANK = 8'h00;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_BG      = 2'd2,
        CFG_FG      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_req;
    } req_t;

    typedef struct packed {
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] character;
        logic [3:0] background;
        logic [3:0] foreground;
        logic       more_dirty;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              cell_we;
        logic [15:0]       cell_data;
        logic              dirty_we;
        logic              dirty_bit;
    } store_req_t;

endpackage

/* rtl/core/ccw_div.sv */
// Restoring divider giving the remainder of the cursor by the column count,
// one bit per cycle. Depends on ccw_pkg.
module ccw_div
    import ccw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CUR_W-1:0] dividend,
    input  logic [7:0]       divisor,
    output logic             busy,
    output logic [7:0]       remainder
);

    localparam int COUNT_W = $clog2(CUR_W + 1);

    logic [7:0]         rem_reg, rem_next;
    logic [CUR_W-1:0]   shift_reg, shift_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [8:0]         trial;

    always_comb
    begin
        rem_next   = rem_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        trial      = {rem_reg, shift_reg[CUR_W-1]};
        if (start)
        begin
            rem_next   = '0;
            shift_next = dividend;
            count_next = COUNT_W'(CUR_W);
        end
        else if (count_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = 8'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[7:0];
            end
            shift_next = {shift_reg[CUR_W-2:0], 1'b0};
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign busy      = (count_reg != '0);
    assign remainder = rem_reg;

endmodule

/* rtl/core/ccw_store.sv */
// Cell store and dirty marks: one write address and one registered read
// address per cycle. Depends on ccw_pkg.
module ccw_store
    import ccw_pkg::*;
(
    input  logic        clk,
    input  store_req_t  req,
    output logic [15:0] cell_q,
    output logic        dirty_q
);

    logic [15:0] cell_mem [STORE_CELLS];
    logic        dirty_mem [STORE_CELLS];
    logic [15:0] cell_q_reg;
    logic        dirty_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.cell_we)
        begin
            cell_mem[req.wr_addr] <= req.cell_data;
        end
        if (req.rd_en)
        begin
            cell_q_reg <= cell_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.dirty_we)
        begin
            dirty_mem[req.wr_addr] <= req.dirty_bit;
        end
        if (req.rd_en)
        begin
            dirty_q_reg <= dirty_mem[req.rd_addr];
        end
    end

    assign cell_q  = cell_q_reg;
    assign dirty_q = dirty_q_reg;

endmodule

/* rtl/core/text_console_cell_writer_core.sv */
// Top level of the text console cell writer: sequencer, configuration
// registers and result register. Depends on ccw_pkg, ccw_div and ccw_store.
//
// After reset the block sweeps the store, blanking every cell and marking it
// dirty, and takes no item meanwhile. A printable, tab, backspace or ignored
// byte passes from acceptance through the geometry, check, byte and second
// check states. A newline starts the divider, which works out the column one
// bit per cycle, and then blanks the rest of the line. A scroll walks all
// 4096 dirty marks, copying each cell up one row and blanking the last row.
// A flush reads the store cell by cell: it scans to the end of the burst and
// on to the next dirty cell, then scans again to emit, each item waiting in
// the result register until it is taken.
module text_console_cell_writer_core
    import ccw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  logic [7:0] cfg_data
);

    typedef enum logic [14:0] {
        S_INIT  = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_GEOM  = 15'b000000000000100,
        S_CHK1  = 15'b000000000001000,
        S_SC    = 15'b000000000010000,
        S_SC_WR = 15'b000000000100000,
        S_BYTE  = 15'b000000001000000,
        S_DIV   = 15'b000000010000000,
        S_NL    = 15'b000000100000000,
        S_CHK2  = 15'b000001000000000,
        S_F1_RD = 15'b000010000000000,
        S_F1_CK = 15'b000100000000000,
        S_F2_RD = 15'b001000000000000,
        S_F2_CK = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       columns_reg;
    logic [5:0]       rows_reg;
    logic [3:0]       bg_reg;
    logic [3:0]       fg_reg;
    logic [CUR_W-1:0] cursor_reg, cursor_next;
    logic [CUR_W-1:0] total_reg, total_next;
    logic [CUR_W-1:0] idx_reg, idx_next;
    logic [CUR_W-1:0] nl_end_reg, nl_end_next;
    logic [6:0]       col_reg, col_next;
    logic [4:0]       row_reg, row_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic             more_reg, more_next;
    logic             search_reg, search_next;
    logic             post_reg, post_next;
    logic [7:0]       byte_reg, byte_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [7:0]       eff_c;
    logic [5:0]       eff_r;
    logic [13:0]      total_prod;
    logic [CUR_W-1:0] c_ext;
    logic [CUR_W-1:0] lrs;
    logic [CUR_W-1:0] bs_cursor;
    logic [15:0]      blank_cell;
    logic [15:0]      cell_q;
    logic             dirty_q;
    logic             div_start;
    logic             div_busy;
    logic [7:0]       div_rem;
    store_req_t       sreq;

    ccw_store u_store (
        .clk     (clk),
        .req     (sreq),
        .cell_q  (cell_q),
        .dirty_q (dirty_q)
    );

    ccw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cursor_reg),
        .divisor   (eff_c),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    always_comb
    begin
        if (columns_reg == '0)
        begin
            eff_c = 8'd1;
        end
        else if (columns_reg > 8'(MAX_COLUMNS))
        begin
            eff_c = 8'(MAX_COLUMNS);
        end
        else
        begin
            eff_c = columns_reg;
        end
        if (rows_reg == '0)
        begin
            eff_r = 6'd1;
        end
        else if (rows_reg > 6'(MAX_ROWS))
        begin
            eff_r = 6'(MAX_ROWS);
        end
        else
        begin
            eff_r = rows_reg;
        end
    end

    assign total_prod = eff_c * eff_r;
    assign c_ext      = {{(CUR_W-8){1'b0}}, eff_c};
    assign lrs        = total_reg - c_ext;
    assign blank_cell = {fg_reg, bg_reg, CHAR_BLANK};
    assign bs_cursor  = (cursor_reg == '0) ? '0 : cursor_reg - CUR_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        nl_end_next    = nl_end_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        emit_next      = emit_reg;
        more_next      = more_reg;
        search_next    = search_reg;
        post_next      = post_reg;
        byte_next      = byte_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        div_start      = 1'b0;
        sreq           = '0;
        sreq.wr_addr   = idx_reg[ADDR_W-1:0];
        sreq.rd_addr   = idx_reg[ADDR_W-1:0];

        case (state_reg)
            S_INIT:
            begin
                sreq.cell_we   = 1'b1;
                sreq.cell_data = '0;
                sreq.dirty_we  = 1'b1;
                sreq.dirty_bit = 1'b1;
                if (idx_reg[ADDR_W-1:0] == '1)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CUR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    byte_next  = req.byte_req;
                    search_next = (req.op == OP_FLUSH);
                    state_next = S_GEOM;
                end
            end
            S_GEOM:
            begin
                total_next = total_prod[CUR_W-1:0];
                idx_next   = '0;
                if (search_reg)
                begin
                    search_next = 1'b0;
                    cnt_next    = '0;
                    more_next   = 1'b0;
                    state_next  = S_F1_RD;
                end
                else
                begin
                    state_next = S_CHK1;
                end
            end
            S_CHK1:
            begin
                post_next = 1'b0;
                state_next = (cursor_reg >= total_reg) ? S_SC : S_BYTE;
            end
            S_SC:
            begin
                if (idx_reg < lrs)
                begin
                    sreq.rd_en   = 1'b1;
                    sreq.rd_addr = ADDR_W'(idx_reg + c_ext);
                    state_next   = S_SC_WR;
                end
                else
                begin
                    sreq.dirty_we  = 1'b1;
                    sreq.dirty_bit = 1'b1;
                    sreq.cell_we   = (idx_reg < total_reg);
                    sreq.cell_data = blank_cell;
                    if (idx_reg[ADDR_W-1:0] == '1)
                    begin
                        idx_next    = '0;
                        cursor_next = lrs;
                        state_next  = post_reg ? S_IDLE : S_BYTE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CUR_W'(1);
                    end
                end
            end
            S_SC_WR:
            begin
                sreq.cell_we   = 1'b1;
                sreq.cell_data = cell_q;
                sreq.dirty_we  = 1'b1;
                sreq.dirty_bit = 1'b1;
                idx_next       = idx_reg + CUR_W'(1);
                state_next     = S_SC;
            end
            S_BYTE:
            begin
                state_next = S_CHK2;
                if (byte_reg == BYTE_NL)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (byte_reg == BYTE_BS)
                begin
                    cursor_next    = bs_cursor;
                    sreq.wr_addr   = bs_cursor[ADDR_W-1:0];
                    sreq.cell_we   = 1'b1;
                    sreq.cell_data = blank_cell;
                    sreq.dirty_we  = 1'b1;
                    sreq.dirty_bit = 1'b1;
                end
                else if (byte_reg == BYTE_TAB)
                begin
                    cursor_next = (cursor_reg & ~CUR_W'(TAB_STEP - 1)) + CUR_W'(TAB_STEP);
                end
                else if (byte_reg >= BYTE_SPACE && byte_reg != BYTE_DEL)
                begin
                    cursor_next    = cursor_reg + CUR_W'(1);
                    sreq.wr_addr   = cursor_reg[ADDR_W-1:0];
                    sreq.cell_we   = 1'b1;
                    sreq.cell_data = {fg_reg, bg_reg, byte_reg};
                    sreq.dirty_we  = 1'b1;
                    sreq.dirty_bit = 1'b1;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    nl_end_next = cursor_reg - {{(CUR_W-8){1'b0}}, div_rem} + c_ext;
                    state_next  = S_NL;
                end
            end
            S_NL:
            begin
                if (cursor_reg < nl_end_reg)
                begin
                    sreq.wr_addr   = cursor_reg[ADDR_W-1:0];
                    sreq.cell_we   = 1'b1;
                    sreq.cell_data = blank_cell;
                    sreq.dirty_we  = 1'b1;
                    sreq.dirty_bit = 1'b1;
                    cursor_next    = cursor_reg + CUR_W'(1);
                end
                else
                begin
                    state_next = S_CHK2;
                end
            end
            S_CHK2:
            begin
                post_next = 1'b1;
                idx_next  = '0;
                state_next = (cursor_reg >= total_reg) ? S_SC : S_IDLE;
            end
            S_F1_RD:
            begin
                if (idx_reg >= total_reg)
                begin
                    if (cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = '0;
                        col_next   = '0;
                        row_next   = '0;
                        emit_next  = '0;
                        state_next = S_F2_RD;
                    end
                end
                else
                begin
                    sreq.rd_en = 1'b1;
                    state_next = S_F1_CK;
                end
            end
            S_F1_CK:
            begin
                idx_next   = idx_reg + CUR_W'(1);
                state_next = S_F1_RD;
                if (dirty_q)
                begin
                    if (search_reg)
                    begin
                        more_next   = 1'b1;
                        search_next = 1'b0;
                        idx_next    = '0;
                        col_next    = '0;
                        row_next    = '0;
                        emit_next   = '0;
                        state_next  = S_F2_RD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (cnt_reg + CNT_W'(1) == CNT_W'(FLUSH_BURST))
                        begin
                            search_next = 1'b1;
                        end
                    end
                end
            end
            S_F2_RD:
            begin
                sreq.rd_en = 1'b1;
                state_next = S_F2_CK;
            end
            S_F2_CK:
            begin
                if (dirty_q)
                begin
                    rsp_next.column     = col_reg;
                    rsp_next.row        = row_reg;
                    rsp_next.character  = cell_q[7:0];
                    rsp_next.background = cell_q[11:8];
                    rsp_next.foreground = cell_q[15:12];
                    rsp_next.more_dirty = more_reg;
                    rsp_next.last       = (emit_reg + CNT_W'(1) == cnt_reg);
                    rsp_valid_next      = 1'b1;
                    sreq.dirty_we       = 1'b1;
                    sreq.dirty_bit      = 1'b0;
                    state_next          = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + CUR_W'(1);
                    if (8'({1'b0, col_reg}) + 8'd1 == eff_c)
                    begin
                        col_next = '0;
                        row_next = row_reg + 5'd1;
                    end
                    else
                    begin
                        col_next = col_reg + 7'd1;
                    end
                    state_next = S_F2_RD;
                end
            end
            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    rsp_valid_next = 1'b0;
                    emit_next      = emit_reg + CNT_W'(1);
                    if (rsp_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CUR_W'(1);
                        if (8'({1'b0, col_reg}) + 8'd1 == eff_c)
                        begin
                            col_next = '0;
                            row_next = row_reg + 5'd1;
                        end
                        else
                        begin
                            col_next = col_reg + 7'd1;
                        end
                        state_next = S_F2_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cursor_reg    <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            nl_end_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            emit_reg      <= '0;
            more_reg      <= 1'b0;
            search_reg    <= 1'b0;
            post_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            nl_end_reg    <= nl_end_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            emit_reg      <= emit_next;
            more_reg      <= more_next;
            search_reg    <= search_next;
            post_reg      <= post_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 8'd80;
            rows_reg    <= 6'd25;
            bg_reg      <= 4'd0;
            fg_reg      <= 4'd15;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_data;
                CFG_ROWS:    rows_reg    <= cfg_data[5:0];
                CFG_BG:      bg_reg      <= cfg_data[3:0];
                CFG_FG:      fg_reg      <= cfg_data[3:0];
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_rsp_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> state_reg == S_OUT)
        else $error("result valid outside the output state");

    a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && rsp.last) |=> state_reg == S_IDLE)
        else $error("flush did not end after its last item");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FLUSH_BURST))
        else $error("burst count beyond limit");

    a_emit_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_F2_RD |-> emit_reg < cnt_reg)
        else $error("emission scan past the counted burst");

endmodule
